### hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants for the complex FIR decimator
// Field widths, register reset values, register indexes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfd_pkg;

  // Default depth of the delay line and of the coefficient store
  localparam int MAX_TAPS_DEF = 64;

  // Item field widths
  localparam int DATA_W    = 16;
  localparam int TAP_IDX_W = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Input tdata: 70 bits of fields padded to 72
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 2 * DATA_W;

  // Arithmetic right shift applied to the accumulator
  localparam int ACC_SHIFT = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] TAP_COUNT_RST  = 7'd64;
  localparam logic [CFG_W-1:0] DECIMATION_RST = 7'd2;

  // Item kinds carried on tuser
  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_TAP_WRITE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_sample;  // push the input sample into the delay line
    logic wr_tap;     // store the input coefficient
    logic start;      // clear accumulators, load read pointers
    logic step;       // issue one tap read and advance pointers
    logic load_out;   // move the scaled result into the output register
  } cfd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;       // MAC pipeline still holds work
    logic out_full;   // output register holds an unsent item
  } cfd_status_t;

endpackage

### hdl/complex_fir_decimator.sv
// ----------------------------------------------------------------------------
// complex_fir_decimator: complex FIR filter with decimation
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata 72b, tuser 1b
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata 32b
//   cfg       in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// A coefficient write or a sample that does not close a group is taken in the
// idle state. A sample that closes a group blocks input through the start
// step, one complex MAC per cycle through the delay-line and coefficient read
// ports, the read/multiply/accumulate drain and the output hand-off.
// A finished result waits in the output register while new items are taken;
// the next result waits for that register to empty. Reset clears the
// delay line through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_fir_decimator #(
  parameter int MAX_TAPS = cfd_pkg::MAX_TAPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_real[15:0], sample_imag[31:16], tap_index[37:32],
  // tap_real[53:38], tap_imag[69:54], zero[71:70]
  input  logic [cfd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // cmd[0]
  input  logic                            s_axis_tuser,
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_real[15:0], out_imag[31:16]
  output logic [cfd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cfd_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int CNT_W = ($clog2(MAX_TAPS + 1) > cfd_pkg::CFG_W) ?
                         $clog2(MAX_TAPS + 1) : cfd_pkg::CFG_W;

  cfd_pkg::cfd_cmd_t    cmd;
  cfd_pkg::cfd_status_t status;
  logic [CNT_W-1:0]     taps;
  logic signed [cfd_pkg::DATA_W-1:0] out_real, out_imag;

  cfd_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status),
    .out_ready_i (m_axis_tready),
    .taps_o      (taps)
  );

  cfd_dp #(
    .MAX_TAPS (MAX_TAPS),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .taps_i        (taps),
    .sample_real_i (s_axis_tdata[15:0]),
    .sample_imag_i (s_axis_tdata[31:16]),
    .tap_index_i   (s_axis_tdata[37:32]),
    .tap_real_i    (s_axis_tdata[53:38]),
    .tap_imag_i    (s_axis_tdata[69:54]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_real_o    (out_real),
    .out_imag_o    (out_imag)
  );

  assign m_axis_tdata = {out_imag, out_real};

endmodule

### hdl/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl: controller of the complex FIR decimator
// Holds the configuration registers and the group phase, sequences the
// per-output multiply-accumulate pass and hands the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfd_ctrl #(
  parameter int MAX_TAPS = cfd_pkg::MAX_TAPS_DEF,
  parameter int CNT_W    = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cfd_pkg::CFG_W-1:0]   cfg_data_i,
  // input handshake
  input  logic                        in_valid_i,
  input  logic                        in_kind_i,
  output logic                        in_ready_o,
  // datapath
  output cfd_pkg::cfd_cmd_t           cmd_o,
  input  cfd_pkg::cfd_status_t        status_i,
  input  logic                        out_ready_i,
  output logic [CNT_W-1:0]            taps_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [CNT_W-1:0] MaxTapsC = CNT_W'(MAX_TAPS);
  localparam logic [CNT_W-1:0] MinTapsC = CNT_W'(8);
  localparam logic [CNT_W-1:0] OneC     = CNT_W'(1);

  logic [2:0]               state_q, state_d;
  logic [cfd_pkg::CFG_W-1:0] tap_count_q, decimation_q;
  logic [5:0]               phase_q, phase_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         taps, dec, rounded, dec_raw;
  logic [6:0]               phase_inc;
  logic                     accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q  <= cfd_pkg::TAP_COUNT_RST;
      decimation_q <= cfd_pkg::DECIMATION_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfd_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg_data_i;
        cfd_pkg::CFG_DECIMATION: decimation_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective tap count: multiple of eight, clamped to 8..MAX_TAPS
  always_comb begin
    rounded = CNT_W'({tap_count_q[6:3], 3'b000});
    taps    = rounded;
    if (rounded < MinTapsC) taps = MinTapsC;
    if (rounded > MaxTapsC) taps = MaxTapsC;
  end

  // Effective decimation: clamped to 1..taps
  always_comb begin
    dec_raw = CNT_W'(decimation_q);
    dec     = dec_raw;
    if (dec_raw == '0) dec = OneC;
    if (dec_raw > taps) dec = taps;
  end

  assign taps_o     = taps;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign phase_inc  = {1'b0, phase_q} + 7'd1;

  // Sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_kind_i == cfd_pkg::CMD_TAP_WRITE) begin
            cmd_o.wr_tap = 1'b1;
          end else begin
            cmd_o.wr_sample = 1'b1;
            if (CNT_W'(phase_inc) < dec) begin
              phase_d = phase_inc[5:0];
            end else begin
              phase_d = '0;
              state_d = S_START;
            end
          end
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        cnt_d       = taps;
        state_d     = S_RUN;
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - OneC;
        if (cnt_q == OneC) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status_i.busy) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hdl/cfd_dp.sv
// ----------------------------------------------------------------------------
// cfd_dp: datapath of the complex FIR decimator
// Circular delay line with per-entry valid bits, coefficient store, one
// pipelined complex MAC (read, multiply, accumulate) and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfd_dp #(
  parameter int MAX_TAPS = cfd_pkg::MAX_TAPS_DEF,
  parameter int CNT_W    = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cfd_pkg::cfd_cmd_t                  cmd_i,
  output cfd_pkg::cfd_status_t               status_o,
  input  logic [CNT_W-1:0]                   taps_i,
  // input item fields
  input  logic signed [cfd_pkg::DATA_W-1:0]  sample_real_i,
  input  logic signed [cfd_pkg::DATA_W-1:0]  sample_imag_i,
  input  logic [cfd_pkg::TAP_IDX_W-1:0]      tap_index_i,
  input  logic signed [cfd_pkg::DATA_W-1:0]  tap_real_i,
  input  logic signed [cfd_pkg::DATA_W-1:0]  tap_imag_i,
  // result item
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [cfd_pkg::DATA_W-1:0]  out_real_o,
  output logic signed [cfd_pkg::DATA_W-1:0]  out_imag_o
);

  localparam int DW    = cfd_pkg::DATA_W;
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  // one bit above the wider of address and index, so the depth fits
  localparam int IDX_W = ((AW > cfd_pkg::TAP_IDX_W) ? AW : cfd_pkg::TAP_IDX_W) + 1;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + 2 + AW;

  localparam logic [AW-1:0]  LastAddr = AW'(MAX_TAPS - 1);
  localparam logic [CNT_W:0] DepthC   = (CNT_W + 1)'(MAX_TAPS);
  localparam logic signed [ACC_W-1:0] SatMax = ACC_W'((2 ** (DW - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SatMin = -SatMax - ACC_W'(1);

  logic [PW-1:0]          dl_mem [MAX_TAPS];
  logic [PW-1:0]          cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]    dl_vld_q;
  logic [AW-1:0]          wp_q, dl_rd_q, cf_rd_q;
  logic [CNT_W:0]         wp_ext, taps_ext, start_sum;
  logic [IDX_W-1:0]       idx_ext;

  logic [PW-1:0]          dl_rdata_q, cf_rdata_q;
  logic                   dl_hit_q, v1_q, v2_q;
  logic signed [DW-1:0]   sr, si, tr, ti;
  logic signed [PW-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW:0]     term_re, term_im;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q, sh_re, sh_im;
  logic signed [DW-1:0]   sat_re, sat_im;
  logic                   out_valid_q;

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    next_addr = (a == LastAddr) ? '0 : a + AW'(1);
  endfunction

  // Write pointer and valid bits of the delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      dl_vld_q <= '0;
    end else if (cmd_i.wr_sample) begin
      wp_q           <= next_addr(wp_q);
      dl_vld_q[wp_q] <= 1'b1;
    end
  end

  // Delay line memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sample) dl_mem[wp_q] <= {sample_imag_i, sample_real_i};
    if (cmd_i.step) begin
      dl_rdata_q <= dl_mem[dl_rd_q];
      dl_hit_q   <= dl_vld_q[dl_rd_q];
    end
  end

  // Coefficient store: indexes beyond the depth are dropped
  assign idx_ext = IDX_W'(tap_index_i);
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tap && (idx_ext < IDX_W'(MAX_TAPS))) begin
      cf_mem[idx_ext[AW-1:0]] <= {tap_imag_i, tap_real_i};
    end
    if (cmd_i.step) cf_rdata_q <= cf_mem[cf_rd_q];
  end

  // Oldest window entry: write pointer minus tap count, wrapped
  assign wp_ext   = (CNT_W + 1)'(wp_q);
  assign taps_ext = (CNT_W + 1)'(taps_i);
  assign start_sum = (wp_ext >= taps_ext) ? (wp_ext - taps_ext)
                                          : (wp_ext + DepthC - taps_ext);

  // Read pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_rd_q <= '0;
      cf_rd_q <= '0;
    end else if (cmd_i.start) begin
      dl_rd_q <= AW'(start_sum);
      cf_rd_q <= '0;
    end else if (cmd_i.step) begin
      dl_rd_q <= next_addr(dl_rd_q);
      cf_rd_q <= next_addr(cf_rd_q);
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
      v2_q <= v1_q;
    end
  end

  // Multiply stage: unwritten delay entries read as zero
  assign sr = dl_hit_q ? signed'(dl_rdata_q[DW-1:0])  : '0;
  assign si = dl_hit_q ? signed'(dl_rdata_q[PW-1:DW]) : '0;
  assign tr = signed'(cf_rdata_q[DW-1:0]);
  assign ti = signed'(cf_rdata_q[PW-1:DW]);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rr_q <= sr * tr;
      p_ii_q <= si * ti;
      p_ri_q <= sr * ti;
      p_ir_q <= si * tr;
    end
  end

  // Accumulate stage
  assign term_re = (PW + 1)'(p_rr_q) - (PW + 1)'(p_ii_q);
  assign term_im = (PW + 1)'(p_ri_q) + (PW + 1)'(p_ir_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + ACC_W'(term_re);
      acc_im_q <= acc_im_q + ACC_W'(term_im);
    end
  end

  // Floor shift and saturation
  assign sh_re = acc_re_q >>> cfd_pkg::ACC_SHIFT;
  assign sh_im = acc_im_q >>> cfd_pkg::ACC_SHIFT;

  always_comb begin
    if (sh_re > SatMax)      sat_re = DW'(SatMax);
    else if (sh_re < SatMin) sat_re = DW'(SatMin);
    else                     sat_re = sh_re[DW-1:0];
    if (sh_im > SatMax)      sat_im = DW'(SatMax);
    else if (sh_im < SatMin) sat_im = DW'(SatMin);
    else                     sat_im = sh_im[DW-1:0];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_real_o <= sat_re;
      out_imag_o <= sat_im;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.busy     = v1_q || v2_q;
  assign status_o.out_full = out_valid_q;

endmodule
